FILE: sv/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and codes of the bitmap page allocator
// Request and result field widths, operation and status codes, bitmap word.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int FUNC_W = 2;
    localparam int IDX_W  = 12;
    localparam int LEN_W  = 13;
    localparam int CNT_W  = 13;
    localparam int STAT_W = 2;

    // bitmap word: 32 pages per memory entry
    localparam int WORD_W = 32;
    localparam int OFS_W  = 5;

    typedef logic [FUNC_W-1:0] t_func;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [OFS_W-1:0]  t_ofs;

    localparam t_func FUNC_ALLOC   = 2'd0;
    localparam t_func FUNC_FREE    = 2'd1;
    localparam t_func FUNC_RESERVE = 2'd2;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_RANGE = 2'd2;

    localparam logic [CNT_W-1:0] PAGE_COUNT_RST = 13'd4096;

    localparam t_ofs  BIT_MAX  = t_ofs'(WORD_W - 1);
    localparam t_word WORD_ALL = {WORD_W{1'b1}};

endpackage

FILE: sv/bpa_if.sv
// ----------------------------------------------------------------------------
// bpa_if: request and result channels of the bitmap page allocator
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bpa_req_if import bpa_pkg::*; ();
    logic              valid;
    logic              ready;
    t_func             func;
    logic [IDX_W-1:0]  page_index;
    logic [LEN_W-1:0]  range_length;

    modport source (output valid, output func, output page_index, output range_length,
                    input ready);
    modport sink   (input valid, input func, input page_index, input range_length,
                    output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  granted_page;
    t_status           status;

    modport source (output valid, output granted_page, output status, input ready);
    modport sink   (input valid, input granted_page, input status, output ready);
endinterface

FILE: sv/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/bitmap_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit: first-fit page allocator over a used-page bitmap
// One used bit per page, held 32 pages to a word in a one-port-read RAM.
//
// i_req carries func, page_index and range_length; o_rsp returns granted_page
// and status, one result per request, in order. i_cfg_we/i_cfg_wdata set the
// page count; the user must write it only while the block is idle, which the block itself does not enforce.
// One request is worked at a time, each word by read-modify-write, one RAM
// word per cycle. A request that touches no memory goes straight to S_OUT;
// free reads and writes back its one word, reserve each word of its run, and
// allocate scans words until it finds a free page. The scan starts at
// a hint word below which all words are known full, so it usually reads a
// single word.
// After reset a clearing pass writes every word with i_req.ready low;
// configuration writes are taken throughout.
// The result sits in an output register: a new request is accepted while it
// waits; a request that finishes while it still waits holds until it drains.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_unit import bpa_pkg::*; #(
    parameter int MAX_PAGES = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    bpa_req_if.sink          i_req,
    bpa_rsp_if.source        o_rsp
);

    localparam int PW    = $clog2(MAX_PAGES);
    localparam int AW    = PW - OFS_W;
    localparam int DEPTH = (MAX_PAGES + WORD_W - 1) / WORD_W;
    // one spare bit so that index plus run length cannot wrap
    localparam int NW    = ((PW + 1 > CNT_W) ? PW + 1 : CNT_W) + 1;
    localparam int GW    = (PW > IDX_W) ? PW : IDX_W;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_FREE = 3'd3;
    localparam logic [2:0] S_RSV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [AW-1:0]    r_addr, n_addr;
    logic [AW-1:0]    r_hint, n_hint;
    logic [AW-1:0]    r_last, n_last;
    t_ofs             r_lo, n_lo;
    t_ofs             r_hi, n_hi;
    t_ofs             r_bit, n_bit;
    logic [IDX_W-1:0] r_res_gr, n_res_gr;
    t_status          r_res_st, n_res_st;
    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_out_gr, n_out_gr;
    t_status          r_out_st, n_out_st;
    logic [CNT_W-1:0] r_page_count;

    logic             ram_we;
    t_word            ram_wdata;
    logic [AW-1:0]    ram_raddr;
    t_word            ram_rdata;

    logic [NW-1:0]    act_n, nm1, idx_ext, rsv_sum, rsv_end, rsv_last;
    logic [AW-1:0]    last_word, idx_word;
    t_word            scan_free, rsv_mask;
    t_ofs             free_pos, rsv_hi;
    logic [PW-1:0]    grant_page;
    logic [GW-1:0]    grant_ext;

    bpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // active page count, limited to the bitmap size
    assign act_n     = (NW'(r_page_count) > NW'(MAX_PAGES)) ? NW'(MAX_PAGES)
                                                            : NW'(r_page_count);
    assign nm1       = act_n - NW'(1);
    assign last_word = nm1[PW-1:OFS_W];

    assign idx_ext   = NW'(i_req.page_index);
    assign idx_word  = idx_ext[PW-1:OFS_W];
    assign rsv_sum   = idx_ext + NW'(i_req.range_length);
    assign rsv_end   = (rsv_sum > act_n) ? act_n : rsv_sum;
    assign rsv_last  = rsv_end - NW'(1);

    // free pages of the word under scan, cut at the active count
    assign scan_free = ~ram_rdata & ((r_addr == last_word)
                                     ? (WORD_ALL >> (BIT_MAX - nm1[OFS_W-1:0]))
                                     : WORD_ALL);

    always_comb begin
        free_pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (scan_free[i]) begin
                free_pos = t_ofs'(i);
            end
        end
    end

    assign grant_page = {r_addr, free_pos};
    assign grant_ext  = GW'(grant_page);

    assign rsv_hi   = (r_addr == r_last) ? r_hi : BIT_MAX;
    assign rsv_mask = (WORD_ALL << r_lo) & (WORD_ALL >> (BIT_MAX - rsv_hi));

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_hint      = r_hint;
        n_last      = r_last;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_bit       = r_bit;
        n_res_gr    = r_res_gr;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid;
        n_out_gr    = r_out_gr;
        n_out_st    = r_out_st;
        ram_we      = 1'b0;
        ram_wdata   = '0;
        ram_raddr   = r_addr;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                ram_we = 1'b1;
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_res_gr = '0;
                    n_res_st = ST_OK;
                    n_state  = S_OUT;
                    unique case (i_req.func)
                        FUNC_ALLOC: begin
                            if (act_n != '0 && r_hint <= last_word) begin
                                n_addr    = r_hint;
                                ram_raddr = r_hint;
                                n_state   = S_SCAN;
                            end else begin
                                n_res_st = ST_FULL;
                            end
                        end
                        FUNC_FREE: begin
                            if (idx_ext < act_n) begin
                                n_addr    = idx_word;
                                ram_raddr = idx_word;
                                n_bit     = idx_ext[OFS_W-1:0];
                                n_state   = S_FREE;
                            end else begin
                                n_res_st = ST_RANGE;
                            end
                        end
                        FUNC_RESERVE: begin
                            // empty or clipped-away runs finish at once
                            if (idx_ext < rsv_end) begin
                                n_addr    = idx_word;
                                ram_raddr = idx_word;
                                n_last    = rsv_last[PW-1:OFS_W];
                                n_lo      = idx_ext[OFS_W-1:0];
                                n_hi      = rsv_last[OFS_W-1:0];
                                n_state   = S_RSV;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (|scan_free) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | (t_word'(1) << free_pos);
                    n_res_gr  = grant_ext[IDX_W-1:0];
                    n_hint    = r_addr;
                    n_state   = S_OUT;
                end else if (r_addr == last_word) begin
                    n_res_st = ST_FULL;
                    n_state  = S_OUT;
                end else begin
                    n_addr    = r_addr + AW'(1);
                    ram_raddr = r_addr + AW'(1);
                end
            end
            S_FREE: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~(t_word'(1) << r_bit);
                if (r_addr < r_hint) begin
                    n_hint = r_addr;
                end
                n_state = S_OUT;
            end
            S_RSV: begin
                // write this word while the next one is read
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | rsv_mask;
                if (r_addr == r_last) begin
                    n_state = S_OUT;
                end else begin
                    n_addr    = r_addr + AW'(1);
                    ram_raddr = r_addr + AW'(1);
                    n_lo      = '0;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_gr    = r_res_gr;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_addr       <= '0;
            r_hint       <= '0;
            r_out_valid  <= 1'b0;
            r_page_count <= PAGE_COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_hint      <= n_hint;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_page_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last   <= n_last;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_bit    <= n_bit;
        r_res_gr <= n_res_gr;
        r_res_st <= n_res_st;
        r_out_gr <= n_out_gr;
        r_out_st <= n_out_st;
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.granted_page = r_out_gr;
    assign o_rsp.status       = r_out_st;

    // mid-run, the word written back is never the one being read
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state == S_RSV && r_addr != r_last) |-> (ram_raddr != r_addr))
        else $error("bitmap read and write hit the same word");

    a_hint_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hint <= AW'(DEPTH - 1))
        else $error("allocation hint beyond the bitmap");

    a_full_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_FULL) |-> (o_rsp.granted_page == '0))
        else $error("full result carries a page");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while another is in work");

endmodule

FILE: dv/tb_bitmap_page_allocator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator_unit: self-checking bench for the page allocator
// Issues allocate, free, reserve and unused-code requests over a range of page counts, with
// random gaps on both channels and long result back-pressure. A shadow bitmap
// predicts each grant and status, which are checked in order of request.
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator_unit;
    import bpa_pkg::*;

    localparam int PAGE_SLOTS    = 4096;
    localparam int GAP_MAX       = 18;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 85;
    localparam int PHASE_NUM     = 12;
    localparam int REPORT_MAX    = 10;

    // the one func code the block ignores
    localparam t_func FUNC_NONE = 2'd3;

    localparam logic [CNT_W-1:0] PHASE_COUNTS [PHASE_NUM] = '{
        13'd64, 13'd4096, 13'd1, 13'd200, 13'd8191, 13'd37,
        13'd0, 13'd4096, 13'd5000, 13'd128, 13'd33, 13'd4096
    };

    typedef struct packed {
        logic [IDX_W-1:0] page;
        t_status          status;
    } t_page_grant;

    class t_grant_board;
        bit               page_used [PAGE_SLOTS];
        logic [CNT_W-1:0] page_count;
        t_page_grant      grants_due [$];
        int unsigned      failures;

        function new();
            foreach (page_used[p]) page_used[p] = 1'b0;
            page_count = PAGE_COUNT_RST;
            failures   = 0;
        endfunction

        function int unsigned active_pages();
            return (int'(page_count) > PAGE_SLOTS) ? PAGE_SLOTS : int'(page_count);
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= REPORT_MAX) begin
                $display("mismatch: %s", msg);
            end
        endfunction

        // shadow bitmap update for one accepted request
        function void record_request(t_func func, logic [IDX_W-1:0] idx,
                                     logic [LEN_W-1:0] len);
            t_page_grant due;
            int unsigned n;
            int unsigned stop_at;
            bit          found;
            n          = active_pages();
            due.page   = '0;
            due.status = ST_OK;
            found      = 1'b0;
            unique case (func)
                FUNC_ALLOC: begin
                    for (int p = 0; p < n; p++) begin
                        if (!found && !page_used[p]) begin
                            found        = 1'b1;
                            page_used[p] = 1'b1;
                            due.page     = IDX_W'(p);
                        end
                    end
                    if (!found) begin
                        due.status = ST_FULL;
                    end
                end
                FUNC_FREE: begin
                    if (int'(idx) < n) begin
                        page_used[idx] = 1'b0;
                    end else begin
                        due.status = ST_RANGE;
                    end
                end
                FUNC_RESERVE: begin
                    // run is clipped at the active count
                    stop_at = int'(idx) + int'(len);
                    if (stop_at > n) begin
                        stop_at = n;
                    end
                    for (int unsigned p = idx; p < stop_at; p++) begin
                        page_used[p] = 1'b1;
                    end
                end
                default: ;
            endcase
            grants_due.push_back(due);
        endfunction

        function void check_grant(logic [IDX_W-1:0] page, t_status status);
            t_page_grant due;
            if (grants_due.size() == 0) begin
                note_failure($sformatf("result page %0d status %0d with no request pending",
                                       page, status));
                return;
            end
            due = grants_due.pop_front();
            if (page !== due.page) begin
                note_failure($sformatf("granted_page expected %0d got %0d", due.page, page));
            end
            if (status !== due.status) begin
                note_failure($sformatf("status expected %0d got %0d", due.status, status));
            end
        endfunction
    endclass

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [CNT_W-1:0] i_cfg_wdata = '0;

    bpa_req_if alloc_req ();
    bpa_rsp_if alloc_rsp ();

    t_grant_board    board;
    int unsigned     req_gap_max     = 0;
    int unsigned     rsp_gap_max     = 0;
    int unsigned     hold_off_cycles = 0;
    int unsigned     cycle_count     = 0;

    bitmap_page_allocator_unit #(
        .MAX_PAGES (PAGE_SLOTS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (alloc_req),
        .o_rsp       (alloc_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned draw_wait(int unsigned max_wait);
        return (max_wait == 0) ? 0 : $urandom_range(0, max_wait);
    endfunction

    // returns at the edge the request was taken; valid is left high
    task automatic issue_request(t_func func, logic [IDX_W-1:0] idx, logic [LEN_W-1:0] len);
        int unsigned gap;
        gap = draw_wait(req_gap_max);
        if (gap > 0) begin
            alloc_req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        alloc_req.valid        <= 1'b1;
        alloc_req.func         <= func;
        alloc_req.page_index   <= idx;
        alloc_req.range_length <= len;
        do @(posedge i_clk); while (!alloc_req.ready);
        board.record_request(func, idx, len);
    endtask

    task automatic wait_drained();
        alloc_req.valid <= 1'b0;
        do @(posedge i_clk); while (board.grants_due.size() != 0);
    endtask

    task automatic write_page_count(logic [CNT_W-1:0] count);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we         <= 1'b0;
        board.page_count = count;
        @(posedge i_clk);
    endtask

    task automatic random_request();
        int unsigned      n;
        int unsigned      pick;
        t_func            func;
        logic [IDX_W-1:0] idx;
        logic [LEN_W-1:0] len;
        n    = board.active_pages();
        pick = $urandom_range(0, 99);
        idx  = IDX_W'($urandom);
        len  = LEN_W'($urandom);
        if (pick < 45) begin
            func = FUNC_ALLOC;
        end else if (pick < 75) begin
            func = FUNC_FREE;
            // mostly in range; the rest stays a raw index, often out of range
            if (n > 0 && pick < 70) begin
                idx = IDX_W'($urandom_range(0, n - 1));
            end
        end else if (pick < 93) begin
            func = FUNC_RESERVE;
            if (pick < 90) begin
                if (n > 0) begin
                    idx = IDX_W'($urandom_range(0, n - 1));
                end
                len = LEN_W'($urandom_range(0, 8));
            end
        end else begin
            func = FUNC_NONE;
        end
        issue_request(func, idx, len);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int unsigned stall;
        alloc_rsp.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        alloc_rsp.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (alloc_rsp.valid && alloc_rsp.ready) begin
                board.check_grant(alloc_rsp.granted_page, alloc_rsp.status);
                if (hold_off_cycles > 0) begin
                    stall           = hold_off_cycles;
                    hold_off_cycles = 0;
                end else begin
                    stall = draw_wait(rsp_gap_max);
                end
                if (stall > 0) begin
                    alloc_rsp.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    alloc_rsp.ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        board = new();
        alloc_req.valid        <= 1'b0;
        alloc_req.func         <= FUNC_ALLOC;
        alloc_req.page_index   <= '0;
        alloc_req.range_length <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register write lands during the clearing pass
        write_page_count(PAGE_COUNT_RST);
        issue_request(FUNC_ALLOC, 12'd0, 13'd0);
        issue_request(FUNC_ALLOC, 12'hfff, 13'h1fff);
        issue_request(FUNC_FREE, 12'd0, 13'd0);
        issue_request(FUNC_FREE, 12'd0, 13'd0);          // already free
        issue_request(FUNC_ALLOC, 12'd0, 13'd0);
        issue_request(FUNC_FREE, 12'hfff, 13'd0);
        issue_request(FUNC_RESERVE, 12'd2, 13'd0);       // zero length
        issue_request(FUNC_RESERVE, 12'd2, 13'h1fff);    // clipped at the count
        issue_request(FUNC_ALLOC, 12'd0, 13'd0);         // full
        issue_request(FUNC_NONE, 12'hfff, 13'h1fff);
        issue_request(FUNC_FREE, 12'hfff, 13'd0);
        issue_request(FUNC_ALLOC, 12'd0, 13'd0);         // top page
        issue_request(FUNC_RESERVE, 12'hfff, 13'd1);     // already used
        issue_request(FUNC_ALLOC, 12'd0, 13'd0);

        wait_drained();
        write_page_count(13'h1fff);                      // above the maximum
        issue_request(FUNC_FREE, 12'd100, 13'd0);
        issue_request(FUNC_ALLOC, 12'd0, 13'd0);

        wait_drained();
        write_page_count(13'd0);
        issue_request(FUNC_ALLOC, 12'd0, 13'd0);
        issue_request(FUNC_FREE, 12'd0, 13'd0);
        issue_request(FUNC_RESERVE, 12'd0, 13'd5);       // start beyond the count

        wait_drained();
        write_page_count(13'd10);
        issue_request(FUNC_FREE, 12'd10, 13'd0);
        issue_request(FUNC_FREE, 12'd9, 13'd0);
        issue_request(FUNC_RESERVE, 12'd9, 13'd4096);
        issue_request(FUNC_FREE, 12'd3, 13'd0);
        issue_request(FUNC_ALLOC, 12'd0, 13'd0);

        for (int k = 0; k < PHASE_NUM; k++) begin
            wait_drained();
            write_page_count(PHASE_COUNTS[k]);
            req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
            rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
            if (k == 1) begin
                // back-to-back requests against a stalled result channel
                req_gap_max     = 0;
                hold_off_cycles = HOLD_CYCLES;
            end
            repeat (PHASE_ITEMS) begin
                random_request();
                if ($urandom_range(0, 39) == 0) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
